// ----- rtl/core/fpadd_pkg.sv -----
// ----------------------------------------------------------------------------
// fpadd_pkg
// Shared types and constants for the single-precision adder.
// ----------------------------------------------------------------------------
package fpadd_pkg;

    localparam int unsigned SIG_W       = 27;
    localparam int unsigned EXP_W       = 8;
    localparam int unsigned FRAC_W      = 23;
    localparam int unsigned QUEUE_DEPTH = 2;

    typedef logic [31:0] t_word;

    typedef struct packed {
        logic             sign_a;
        logic             sign_b;
        logic [EXP_W-1:0] exp;
        logic [SIG_W-1:0] sig_a;
        logic [SIG_W-1:0] sig_b;
    } t_job;

    localparam int unsigned JOB_W = $bits(t_job);

endpackage

// ----- rtl/core/fpadd_if.sv -----
// ----------------------------------------------------------------------------
// fpadd_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface fpadd_if #(
    parameter int unsigned W = 32
);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/float32_adder.sv -----
// ----------------------------------------------------------------------------
// float32_adder
// Single-precision adder: front aligns, queue decouples, back adds and rounds.
// An input beat passes the front register, the queue and the back add and output registers.
// Throughput: one operand pair per cycle when the outputs do not stall, set by the fully pipelined back end.
// Reset: synchronous active-low; clears all valid flags and queue pointers.
// ----------------------------------------------------------------------------
module float32_adder #(
    parameter int unsigned QUEUE_DEPTH = fpadd_pkg::QUEUE_DEPTH
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    fpadd_if.sink   i_in_a,
    fpadd_if.sink   i_in_b,
    fpadd_if.source o_sum,
    fpadd_if.source o_range
);
    import fpadd_pkg::*;

    logic front_ready, fq_valid, fq_ready, qb_valid, qb_ready, out_valid;
    t_job fq_job, qb_job;
    t_word sum_word;
    logic  range_flag;
    logic  in_fire;
    logic  out_ready;

    assign in_fire = i_in_a.valid && i_in_b.valid;
    assign i_in_a.ready = front_ready && i_in_b.valid;
    assign i_in_b.ready = front_ready && i_in_a.valid;

    fpadd_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(in_fire), .o_ready(front_ready),
        .i_operand_a(i_in_a.data), .i_operand_b(i_in_b.data),
        .o_valid(fq_valid), .i_ready(fq_ready), .o_job(fq_job)
    );

    fpadd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(fq_valid), .o_ready(fq_ready), .i_job(fq_job),
        .o_valid(qb_valid), .i_ready(qb_ready), .o_job(qb_job)
    );

    assign out_ready = o_sum.ready && o_range.ready;

    fpadd_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(qb_valid), .o_ready(qb_ready), .i_job(qb_job),
        .o_valid(out_valid), .i_ready(out_ready),
        .o_sum_word(sum_word), .o_range(range_flag)
    );

    // offer each output beat only when the other channel can take it too
    assign o_sum.valid   = out_valid && o_range.ready;
    assign o_sum.data    = sum_word;
    assign o_range.valid = out_valid && o_sum.ready;
    assign o_range.data  = range_flag;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_valid && !out_ready) |=>
            out_valid && $stable(sum_word) && $stable(range_flag))
        else $error("output beat changed while stalled");

    a_out_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_sum.valid)
        else $error("output valid after reset");

    a_queue_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fq_valid && !fq_ready) |=> fq_valid && $stable(fq_job))
        else $error("front beat lost while queue full");
endmodule

// ----- rtl/core/fpadd_front.sv -----
// ----------------------------------------------------------------------------
// fpadd_front
// Unpack operands and align the smaller-exponent significand; one beat per cycle if not stalled.
// ----------------------------------------------------------------------------
module fpadd_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  fpadd_pkg::t_word     i_operand_a,
    input  fpadd_pkg::t_word     i_operand_b,
    output logic                 o_valid,
    input  logic                 i_ready,
    output fpadd_pkg::t_job      o_job
);
    import fpadd_pkg::*;

    logic             r_valid;
    t_job             r_job;
    t_job             n_job;
    logic [EXP_W-1:0] ea, eb, exp_diff;
    logic [SIG_W-1:0] ma, mb, shin, shout;
    logic             a_big;

    function automatic logic [SIG_W-1:0] align(input logic [SIG_W-1:0] sig,
                                               input logic [EXP_W-1:0] d);
        logic [SIG_W-1:0] kept;
        logic [SIG_W-1:0] msk;
        begin
            if (d >= EXP_W'(SIG_W + 1)) begin
                align = SIG_W'(1);
            end else begin
                kept  = sig >> d;
                msk   = ~({SIG_W{1'b1}} << d);
                align = kept | SIG_W'((sig & msk) != '0);
            end
        end
    endfunction

    assign ea       = i_operand_a[30:23];
    assign eb       = i_operand_b[30:23];
    assign ma       = {1'b1, i_operand_a[22:0], 3'b000};
    assign mb       = {1'b1, i_operand_b[22:0], 3'b000};
    assign a_big    = ea >= eb;
    assign exp_diff = a_big ? ea - eb : eb - ea;
    assign shin     = a_big ? mb : ma;
    assign shout    = align(shin, exp_diff);

    always_comb begin
        n_job.sign_a = i_operand_a[31];
        n_job.sign_b = i_operand_b[31];
        n_job.exp    = a_big ? ea : eb;
        n_job.sig_a  = a_big ? ma : shout;
        n_job.sig_b  = a_big ? shout : mb;
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_job   = r_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_job <= n_job;
        end
    end
endmodule

// ----- rtl/core/fpadd_queue.sv -----
// ----------------------------------------------------------------------------
// fpadd_queue
// Short FIFO between front and back.
// ----------------------------------------------------------------------------
module fpadd_queue #(
    parameter int unsigned DEPTH = fpadd_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  fpadd_pkg::t_job i_job,
    output logic            o_valid,
    input  logic            i_ready,
    output fpadd_pkg::t_job o_job
);
    import fpadd_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_job              r_mem [DEPTH];
    logic [AW-1:0]     r_wp, r_rp;
    logic [AW:0]       r_cnt;
    logic              push, pop;

    assign o_ready = r_cnt != (AW+1)'(DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_job   = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + AW'(1);
            end
            if (pop) begin
                r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + AW'(1);
            end
            r_cnt <= r_cnt + (AW+1)'(push) - (AW+1)'(pop);
        end
        if (push) begin
            r_mem[r_wp] <= i_job;
        end
    end
endmodule

// ----- rtl/core/fpadd_back.sv -----
// ----------------------------------------------------------------------------
// fpadd_back
// Add or subtract, normalise, round; two register stages, the second being the output register.
// ----------------------------------------------------------------------------
module fpadd_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  fpadd_pkg::t_job  i_job,
    output logic             o_valid,
    input  logic             i_ready,
    output fpadd_pkg::t_word o_sum_word,
    output logic             o_range
);
    import fpadd_pkg::*;

    // stage 1: add
    logic             r1_valid;
    logic             r1_sign;
    logic [EXP_W-1:0] r1_exp;
    logic [SIG_W:0]   r1_sum;
    // stage 2: output
    logic             r2_valid;
    t_word            r2_word;
    logic             r2_range;

    logic             adv1, adv2;
    logic             a_gt, a_lt, rsign;
    logic [SIG_W:0]   big, lesser, sum;
    logic [SIG_W-1:0] nsum;
    logic [4:0]       lz;
    logic signed [EXP_W+2:0] e;
    logic [FRAC_W-1:0] frac;
    logic [FRAC_W:0]   frac_inc;
    logic [2:0]        grs;
    logic              rnd;

    assign adv2    = !r2_valid || i_ready;
    assign adv1    = !r1_valid || adv2;
    assign o_ready = adv1;

    assign a_gt   = i_job.sig_a > i_job.sig_b;
    assign a_lt   = i_job.sig_a < i_job.sig_b;
    assign rsign  = (i_job.sign_a && i_job.sign_b)
                 || (!i_job.sign_a && i_job.sign_b && a_lt)
                 || (i_job.sign_a && !i_job.sign_b && a_gt);
    assign big    = {1'b0, a_gt ? i_job.sig_a : i_job.sig_b};
    assign lesser = {1'b0, a_gt ? i_job.sig_b : i_job.sig_a};
    assign sum    = (i_job.sign_a == i_job.sign_b) ? big + lesser : big - lesser;

    always_comb begin
        lz = '0;
        for (int i = 0; i < SIG_W; i++) begin
            if (r1_sum[i]) begin
                lz = 5'(SIG_W - 1 - i);
            end
        end
    end

    always_comb begin
        if (r1_sum[SIG_W]) begin
            nsum = r1_sum[SIG_W:1] | SIG_W'(r1_sum[0]);
            e    = $signed({3'b000, r1_exp}) + 11'sd1;
        end else begin
            nsum = r1_sum[SIG_W-1:0] << lz;
            e    = $signed({3'b000, r1_exp}) - $signed({6'b0, lz});
        end
        frac     = nsum[SIG_W-2:3];
        grs      = nsum[2:0];
        rnd      = (grs > 3'd4) || (grs == 3'd4 && frac[0]);
        frac_inc = {1'b0, frac} + (FRAC_W+1)'(rnd);
        if (frac_inc[FRAC_W]) begin
            e = e + 11'sd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
        end else begin
            if (adv1) r1_valid <= i_valid;
            if (adv2) r2_valid <= r1_valid;
        end
        if (adv1 && i_valid) begin
            r1_sign <= rsign;
            r1_exp  <= i_job.exp;
            r1_sum  <= sum;
        end
        if (adv2 && r1_valid) begin
            if (r1_sum == '0) begin
                r2_word  <= '0;
                r2_range <= 1'b0;
            end else begin
                r2_word  <= {r1_sign, e[EXP_W-1:0], frac_inc[FRAC_W-1:0]};
                r2_range <= (e < 11'sd1) || (e > 11'sd254);
            end
        end
    end

    assign o_valid    = r2_valid;
    assign o_sum_word = r2_word;
    assign o_range    = r2_range;
endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives operand pairs into float32_adder over its two operand channels and checks
// every sum and range flag against a behavioural adder or typed row result. A short
// table of edge cases runs first, then random pairs with random gaps on both sides.
// ----------------------------------------------------------------------------
module testbench;
    import fpadd_pkg::*;

    localparam int unsigned N_RANDOM   = 680;
    localparam int unsigned IDLE_LIMIT = 4000;
    localparam int unsigned HOLD_LEN   = 200;

    typedef struct packed {
        t_word sum;
        logic  oor;
    } t_sum_res;

    typedef struct {
        t_word    a;
        t_word    b;
        logic     typed;
        t_sum_res res;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    fpadd_if #(.W(32)) in_a ();
    fpadd_if #(.W(32)) in_b ();
    fpadd_if #(.W(32)) sum_ch ();
    fpadd_if #(.W(1))  range_ch ();

    float32_adder u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in_a  (in_a),
        .i_in_b  (in_b),
        .o_sum   (sum_ch),
        .o_range (range_ch)
    );

    always #10 i_clk = ~i_clk;

    t_word    a_beats[$];
    t_word    b_beats[$];
    logic     typed_q[$];
    t_sum_res typed_res_q[$];
    t_word    sums_due[$];
    logic     flags_due[$];
    int       n_errors = 0;
    int       idle_cycles = 0;
    logic     hold_req = 1'b0;

    t_row directed[] = '{
        '{32'h3F80_0000, 32'h3F80_0000, 1'b1, '{32'h4000_0000, 1'b0}},
        '{32'h3F80_0000, 32'hBF80_0000, 1'b1, '{32'h0000_0000, 1'b0}},
        '{32'h7F80_0000, 32'h7F80_0000, 1'b1, '{32'h0000_0000, 1'b1}},
        '{32'hFF80_0000, 32'hFF80_0000, 1'b1, '{32'h8000_0000, 1'b1}},
        '{32'h0000_0000, 32'h0000_0000, 1'b0, '0},
        '{32'h8000_0000, 32'h0000_0000, 1'b0, '0},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0},
        '{32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0},
        '{32'h7F7F_FFFF, 32'h7F7F_FFFF, 1'b0, '0},
        '{32'h3FFF_FFFF, 32'h3400_0000, 1'b0, '0},
        '{32'h3F80_0001, 32'hBF80_0000, 1'b0, '0},
        '{32'h3F80_0000, 32'hBF7F_FFFF, 1'b0, '0},
        '{32'h0080_0000, 32'h8000_0000, 1'b0, '0},
        '{32'h3F80_0000, 32'h3380_0000, 1'b0, '0},
        '{32'h3F80_0001, 32'h3380_0000, 1'b0, '0},
        '{32'h3F80_0000, 32'h3380_0001, 1'b0, '0},
        '{32'h3F80_0000, 32'h0000_0001, 1'b0, '0},
        '{32'hBF80_0000, 32'h2000_0001, 1'b0, '0},
        '{32'h4B00_0000, 32'h3F00_0000, 1'b0, '0},
        '{32'h0000_0000, 32'hFF80_0000, 1'b0, '0},
        '{32'h3FC0_0000, 32'hBF80_0000, 1'b0, '0}
    };

    function automatic logic [27:0] align_sig(logic [27:0] sig, int unsigned shift_n);
        logic [27:0] kept;
        if (shift_n == 0) return sig;
        if (shift_n >= 28) return (sig != 0) ? 28'd1 : 28'd0;
        kept = sig >> shift_n;
        if ((sig & ((28'd1 << shift_n) - 28'd1)) != 0) kept[0] = 1'b1;
        return kept;
    endfunction

    function automatic t_sum_res add_predict(t_word a, t_word b);
        logic [27:0] ma, mb, big, lit, s;
        logic [22:0] frac;
        logic [2:0]  grs;
        logic        rsign;
        int          e;
        t_sum_res    r;
        ma = {5'b00001, a[22:0]} << 3;
        mb = {5'b00001, b[22:0]} << 3;
        if (a[30:23] >= b[30:23]) begin
            e  = int'(a[30:23]);
            mb = align_sig(mb, a[30:23] - b[30:23]);
        end else begin
            e  = int'(b[30:23]);
            ma = align_sig(ma, b[30:23] - a[30:23]);
        end
        rsign = (a[31] && b[31]) || (!a[31] && b[31] && ma < mb)
                || (a[31] && !b[31] && ma > mb);
        big = (ma > mb) ? ma : mb;
        lit = (ma > mb) ? mb : ma;
        s   = (a[31] == b[31]) ? big + lit : big - lit;
        if (s == 0) return '0;
        if (s[27]) begin
            s = {1'b0, s[27:1]} | {27'd0, s[0]};
            e = e + 1;
        end else begin
            while (!s[26]) begin
                s = s << 1;
                e = e - 1;
            end
        end
        frac = s[25:3];
        grs  = s[2:0];
        if (grs > 3'd4 || (grs == 3'd4 && frac[0])) begin
            frac = frac + 23'd1;
            if (frac == 0) e = e + 1;
        end
        r.sum = {rsign, e[7:0], frac};
        r.oor = (e < 1 || e > 254);
        return r;
    endfunction

    task automatic report(string what, t_word got, t_word want);
        n_errors++;
        $display("mismatch %s: got %h want %h", what, got, want);
    endtask

    // sample at the falling edge: a beat seen here is taken at the next rising edge
    always @(negedge i_clk) begin
        t_sum_res r;
        logic     any;
        any = 1'b0;
        if (i_rst_n) begin
            if (in_a.valid && in_a.ready) begin a_beats.push_back(in_a.data); any = 1'b1; end
            if (in_b.valid && in_b.ready) begin b_beats.push_back(in_b.data); any = 1'b1; end
            while (a_beats.size() > 0 && b_beats.size() > 0) begin
                r = add_predict(a_beats.pop_front(), b_beats.pop_front());
                if (typed_q.pop_front()) r = typed_res_q.pop_front();
                else void'(typed_res_q.pop_front());
                sums_due.push_back(r.sum);
                flags_due.push_back(r.oor);
            end
            if (sum_ch.valid && sum_ch.ready) begin
                any = 1'b1;
                if (sums_due.size() == 0) report("unexpected sum", sum_ch.data, 0);
                else if (sum_ch.data !== sums_due[0]) begin
                    report("sum", sum_ch.data, sums_due.pop_front());
                end else void'(sums_due.pop_front());
            end
            if (range_ch.valid && range_ch.ready) begin
                any = 1'b1;
                if (flags_due.size() == 0) report("unexpected flag", range_ch.data, 0);
                else if (range_ch.data !== flags_due[0]) begin
                    report("range flag", range_ch.data, flags_due.pop_front());
                end else void'(flags_due.pop_front());
            end
            idle_cycles = any ? 0 : idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    function automatic int draw_gap(logic quiet);
        return quiet ? 0 : $urandom_range(0, 18);
    endfunction

    task automatic send_pair(t_word a, t_word b, t_row row, int gap);
        logic done_a, done_b, take_a, take_b;
        typed_q.push_back(row.typed);
        typed_res_q.push_back(row.res);
        in_a.valid <= 1'b1;
        in_a.data  <= a;
        in_b.valid <= 1'b1;
        in_b.data  <= b;
        done_a = 1'b0;
        done_b = 1'b0;
        while (!(done_a && done_b)) begin
            @(negedge i_clk);
            take_a = !done_a && in_a.valid && in_a.ready;
            take_b = !done_b && in_b.valid && in_b.ready;
            @(posedge i_clk);
            done_a |= take_a;
            done_b |= take_b;
            if (!(done_a && done_b)) begin
                if (take_a) in_a.valid <= 1'b0;
                if (take_b) in_b.valid <= 1'b0;
            end else if (gap > 0) begin
                in_a.valid <= 1'b0;
                in_b.valid <= 1'b0;
            end
        end
        repeat (gap) @(posedge i_clk);
    endtask

    function automatic t_word rand_word(int unsigned kind, t_word other);
        t_word w;
        w = $urandom();
        case (kind)
            0: ;
            1: w[30:23] = other[30:23] + 8'($urandom_range(0, 3)) - 8'd1;
            2: begin w[30:23] = other[30:23]; w[31] = ~other[31]; end
            3: begin
                w[30:23] = other[30:23] - 8'($urandom_range(20, 40));
                w[22:0]  = other[22:0] ^ (23'd1 << $urandom_range(0, 22));
            end
            default: w[30:23] = 8'($urandom_range(100, 154));
        endcase
        return w;
    endfunction

    // receivers: random stalls, one long hold-off on request
    initial begin
        int gap;
        logic held;
        held = 1'b0;
        sum_ch.ready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            gap = (hold_req && !held) ? HOLD_LEN : draw_gap($urandom_range(0, 3) == 0);
            if (gap == HOLD_LEN) held = 1'b1;
            if (gap > 0) begin
                sum_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            sum_ch.ready <= 1'b1;
            do @(negedge i_clk); while (!sum_ch.valid);
            @(posedge i_clk);
        end
    end

    initial begin
        int gap;
        logic held;
        held = 1'b0;
        range_ch.ready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            gap = (hold_req && !held) ? HOLD_LEN : draw_gap($urandom_range(0, 3) == 0);
            if (gap == HOLD_LEN) held = 1'b1;
            if (gap > 0) begin
                range_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            range_ch.ready <= 1'b1;
            do @(negedge i_clk); while (!range_ch.valid);
            @(posedge i_clk);
        end
    end

    initial begin
        t_row  blank;
        t_word a, b;
        logic  quiet;
        blank = '{'0, '0, 1'b0, '0};
        in_a.valid <= 1'b0;
        in_a.data  <= '0;
        in_b.valid <= 1'b0;
        in_b.data  <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (directed[i]) begin
            send_pair(directed[i].a, directed[i].b, directed[i], draw_gap(i < 8));
        end
        quiet = 1'b0;
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i % 40 == 0) quiet = ($urandom_range(0, 2) == 0);
            if (i == 250) hold_req = 1'b1;
            if (i == 450) begin
                while (sums_due.size() > 0 || flags_due.size() > 0 || a_beats.size() > 0
                       || b_beats.size() > 0)
                    @(posedge i_clk);
            end
            a = rand_word(0, '0);
            if ($urandom_range(0, 3) == 0) a[30:23] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            b = rand_word($urandom_range(0, 4), a);
            send_pair(a, b, blank, draw_gap(quiet));
        end
        in_a.valid <= 1'b0;
        in_b.valid <= 1'b0;
        while (sums_due.size() > 0 || flags_due.size() > 0 || a_beats.size() > 0
               || b_beats.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
